FILE: sv/dtis_pkg.sv
// Package for the dual tuner bring-up sequencer.
// Action codes, phase constants, control word type and the microcode ROM.
// No dependencies.
`timescale 1ns / 1ps

package dtis_pkg;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_CMD         = 3'd1,
    ACT_STATUS      = 3'd2,
    ACT_RST_ASSERT  = 3'd3,
    ACT_RST_RELEASE = 3'd4
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // byte source of one microcode step
  typedef enum logic [3:0] {
    SRC_CONST,
    SRC_FLAGS,
    SRC_TUNE_HI,
    SRC_TUNE_LO,
    SRC_SR_HI,
    SRC_SR_LO,
    SRC_RCF_HI,
    SRC_RCF_LO,
    SRC_RCP_HI,
    SRC_RCP_LO
  } src_e;

  typedef struct packed {
    logic       last;
    src_e       src;
    logic [7:0] lit;
  } uword_t;

  localparam int PcW = 5;

  localparam logic [3:0] PH_DOWN       = 4'd0;
  localparam logic [3:0] PH_INT_UPDATE = 4'd5;
  localparam logic [3:0] PH_INT_CLR    = 4'd6;
  localparam logic [3:0] PH_UP         = 4'd8;

  localparam logic [1:0] BP_DONE    = 2'd0;
  localparam logic [1:0] BP_CHECK   = 2'd1;
  localparam logic [1:0] BP_READING = 2'd2;

  localparam logic [2:0] CFG_TUNE_FREQ       = 3'd0;
  localparam logic [2:0] CFG_TUNE_MODE_FLAGS = 3'd1;
  localparam logic [2:0] CFG_SAMPLE_RATE     = 3'd2;
  localparam logic [2:0] CFG_REFCLK_FREQ     = 3'd3;
  localparam logic [2:0] CFG_REFCLK_PRESCALE = 3'd4;

  localparam logic [15:0] RST_TUNE_FREQ       = 16'd9370;
  localparam logic [7:0]  RST_TUNE_MODE_FLAGS = 8'd1;
  localparam logic [15:0] RST_SAMPLE_RATE     = 16'd48000;
  localparam logic [15:0] RST_REFCLK_FREQ     = 16'd32733;
  localparam logic [15:0] RST_REFCLK_PRESCALE = 16'd4143;

  // first program step of each command phase
  function automatic logic [PcW-1:0] ucode_entry(logic [3:0] ph);
    logic [PcW-1:0] pc;
    unique case (ph)
      4'd1:    pc = 5'd0;
      4'd2:    pc = 5'd3;
      4'd3:    pc = 5'd9;
      4'd4:    pc = 5'd15;
      4'd5:    pc = 5'd20;
      4'd6:    pc = 5'd21;
      4'd7:    pc = 5'd23;
      default: pc = 5'd0;
    endcase
    return pc;
  endfunction

  function automatic uword_t ucode_rom(logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      // power up
      5'd0:  w = '{1'b0, SRC_CONST, 8'h01};
      5'd1:  w = '{1'b0, SRC_CONST, 8'h00};
      5'd2:  w = '{1'b1, SRC_CONST, 8'hB5};
      // refclk freq property
      5'd3:  w = '{1'b0, SRC_CONST, 8'h12};
      5'd4:  w = '{1'b0, SRC_CONST, 8'h00};
      5'd5:  w = '{1'b0, SRC_CONST, 8'h02};
      5'd6:  w = '{1'b0, SRC_CONST, 8'h01};
      5'd7:  w = '{1'b0, SRC_RCF_HI, 8'h00};
      5'd8:  w = '{1'b1, SRC_RCF_LO, 8'h00};
      // refclk prescale property
      5'd9:  w = '{1'b0, SRC_CONST, 8'h12};
      5'd10: w = '{1'b0, SRC_CONST, 8'h00};
      5'd11: w = '{1'b0, SRC_CONST, 8'h02};
      5'd12: w = '{1'b0, SRC_CONST, 8'h02};
      5'd13: w = '{1'b0, SRC_RCP_HI, 8'h00};
      5'd14: w = '{1'b1, SRC_RCP_LO, 8'h00};
      // tune
      5'd15: w = '{1'b0, SRC_CONST, 8'h20};
      5'd16: w = '{1'b0, SRC_FLAGS, 8'h00};
      5'd17: w = '{1'b0, SRC_TUNE_HI, 8'h00};
      5'd18: w = '{1'b0, SRC_TUNE_LO, 8'h00};
      5'd19: w = '{1'b1, SRC_CONST, 8'h00};
      // interrupt update
      5'd20: w = '{1'b1, SRC_CONST, 8'h14};
      // interrupt clear
      5'd21: w = '{1'b0, SRC_CONST, 8'h22};
      5'd22: w = '{1'b1, SRC_CONST, 8'h01};
      // sample rate property
      5'd23: w = '{1'b0, SRC_CONST, 8'h12};
      5'd24: w = '{1'b0, SRC_CONST, 8'h00};
      5'd25: w = '{1'b0, SRC_CONST, 8'h01};
      5'd26: w = '{1'b0, SRC_CONST, 8'h04};
      5'd27: w = '{1'b0, SRC_SR_HI, 8'h00};
      5'd28: w = '{1'b1, SRC_SR_LO, 8'h00};
      default: w = '{1'b1, SRC_CONST, 8'h00};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/dual_tuner_init_sequencer.sv
// Dual tuner bring-up sequencer, top level.
// Microcoded byte emitter over a dispatch on the tuner phase; uses dtis_pkg.
//
// channel | dir | handshake                | payload
// in      | in  | in_valid_i / in_stall_o  | req_type, bus_busy, power_on, reply_*
// out     | out | out_valid_o / out_stall_i| action, target_tuner, cmd_byte, last,
//         |     |                          | up_mask, all_ready
// cfg     | in  | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A single-result tick puts its result in the output register at acceptance. A
// command tick emits its command bytes (1 to 6) one ROM step per cycle while the
// output is not stalled, and holds the input stalled until its last byte.
// Reset is asynchronous, active low; no clearing pass. A stalled output holds
// the sequencer and the input side.
`timescale 1ns / 1ps

module dual_tuner_init_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic       bus_busy_i,
  input  logic       power_on_i,
  input  logic       reply_tuner_i,
  input  logic       reply_cts_i,
  input  logic       reply_stcint_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic       target_tuner_o,
  output logic [7:0] cmd_byte_o,
  output logic       last_o,
  output logic [1:0] up_mask_o,
  output logic       all_ready_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  dtis_pkg::state_e state_q, state_d;
  logic [dtis_pkg::PcW-1:0] pc_q, pc_d;
  logic [3:0] seq_q [2];
  logic [3:0] seq_d [2];
  logic [1:0] bus_q [2];
  logic [1:0] bus_d [2];
  logic       cur_q, cur_d;
  logic [1:0] cts_q, cts_d;
  logic [1:0] stc_q, stc_d;
  logic [1:0] up_q, up_d;
  logic       run_tgt_q, run_tgt_d;

  logic [15:0] tune_freq_q, sample_rate_q, refclk_freq_q, refclk_prescale_q;
  logic [7:0]  tune_flags_q;

  logic                 out_valid_q, out_valid_d;
  dtis_pkg::action_e    act_q, act_d;
  logic                 tgt_q, tgt_d;
  logic [7:0]           byte_q, byte_d;
  logic                 last_q, last_d;
  logic [1:0]           mask_q, mask_d;

  logic            out_free;
  logic            accept;
  logic            t;
  logic [3:0]      ph;
  dtis_pkg::uword_t uw;
  logic [7:0]      src_byte;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != dtis_pkg::ST_IDLE) || !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign t           = ~cur_q;
  assign ph          = (seq_q[t] > dtis_pkg::PH_UP) ? dtis_pkg::PH_DOWN : seq_q[t];
  assign uw          = dtis_pkg::ucode_rom(pc_q);

  always_comb begin
    unique case (uw.src)
      dtis_pkg::SRC_CONST:   src_byte = uw.lit;
      dtis_pkg::SRC_FLAGS:   src_byte = tune_flags_q;
      dtis_pkg::SRC_TUNE_HI: src_byte = tune_freq_q[15:8];
      dtis_pkg::SRC_TUNE_LO: src_byte = tune_freq_q[7:0];
      dtis_pkg::SRC_SR_HI:   src_byte = sample_rate_q[15:8];
      dtis_pkg::SRC_SR_LO:   src_byte = sample_rate_q[7:0];
      dtis_pkg::SRC_RCF_HI:  src_byte = refclk_freq_q[15:8];
      dtis_pkg::SRC_RCF_LO:  src_byte = refclk_freq_q[7:0];
      dtis_pkg::SRC_RCP_HI:  src_byte = refclk_prescale_q[15:8];
      dtis_pkg::SRC_RCP_LO:  src_byte = refclk_prescale_q[7:0];
      default:               src_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    seq_d       = seq_q;
    bus_d       = bus_q;
    cur_d       = cur_q;
    cts_d       = cts_q;
    stc_d       = stc_q;
    up_d        = up_q;
    run_tgt_d   = run_tgt_q;
    out_valid_d = out_valid_q && out_stall_i;
    act_d       = act_q;
    tgt_d       = tgt_q;
    byte_d      = byte_q;
    last_d      = last_q;
    mask_d      = mask_q;

    unique case (state_q)
      dtis_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_type_i) begin
            cts_d[reply_tuner_i] = reply_cts_i;
            stc_d[reply_tuner_i] = reply_stcint_i;
          end else if (!bus_busy_i) begin
            cur_d = t;
            if (bus_q[t] == dtis_pkg::BP_CHECK) begin
              bus_d[t]    = dtis_pkg::BP_READING;
              out_valid_d = 1'b1;
              act_d       = dtis_pkg::ACT_STATUS;
              tgt_d       = t;
              byte_d      = 8'h00;
              last_d      = 1'b1;
              mask_d      = up_q;
            end else if (bus_q[t] == dtis_pkg::BP_READING) begin
              bus_d[t] = cts_q[t] ? dtis_pkg::BP_DONE : dtis_pkg::BP_CHECK;
            end else begin
              bus_d[t] = dtis_pkg::BP_DONE;
              seq_d[t] = ph;
              if (ph == dtis_pkg::PH_UP) begin
                if (!power_on_i) begin
                  seq_d[t]    = dtis_pkg::PH_DOWN;
                  out_valid_d = 1'b1;
                  act_d       = dtis_pkg::ACT_RST_ASSERT;
                end
              end else if (ph == dtis_pkg::PH_DOWN) begin
                if (power_on_i) begin
                  seq_d[t]    = 4'd1;
                  out_valid_d = 1'b1;
                  act_d       = dtis_pkg::ACT_RST_RELEASE;
                end
              end else if (ph == dtis_pkg::PH_INT_CLR && !stc_q[t]) begin
                seq_d[t] = dtis_pkg::PH_INT_UPDATE;
              end else begin
                seq_d[t]  = ph + 4'd1;
                bus_d[t]  = dtis_pkg::BP_CHECK;
                pc_d      = dtis_pkg::ucode_entry(ph);
                run_tgt_d = t;
                state_d   = dtis_pkg::ST_RUN;
              end
              up_d[t] = (seq_d[t] == dtis_pkg::PH_UP);
              tgt_d   = t;
              byte_d  = 8'h00;
              last_d  = 1'b1;
              mask_d  = up_d;
            end
          end
        end
      end
      dtis_pkg::ST_RUN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          act_d       = dtis_pkg::ACT_CMD;
          tgt_d       = run_tgt_q;
          byte_d      = src_byte;
          last_d      = uw.last;
          mask_d      = up_q;
          pc_d        = pc_q + 1'b1;
          if (uw.last) begin
            state_d = dtis_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = dtis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtis_pkg::ST_IDLE;
      pc_q        <= '0;
      seq_q[0]    <= dtis_pkg::PH_DOWN;
      seq_q[1]    <= dtis_pkg::PH_DOWN;
      bus_q[0]    <= dtis_pkg::BP_DONE;
      bus_q[1]    <= dtis_pkg::BP_DONE;
      cur_q       <= 1'b1;
      cts_q       <= '0;
      stc_q       <= '0;
      up_q        <= '0;
      run_tgt_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      seq_q       <= seq_d;
      bus_q       <= bus_d;
      cur_q       <= cur_d;
      cts_q       <= cts_d;
      stc_q       <= stc_d;
      up_q        <= up_d;
      run_tgt_q   <= run_tgt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tune_freq_q       <= dtis_pkg::RST_TUNE_FREQ;
      tune_flags_q      <= dtis_pkg::RST_TUNE_MODE_FLAGS;
      sample_rate_q     <= dtis_pkg::RST_SAMPLE_RATE;
      refclk_freq_q     <= dtis_pkg::RST_REFCLK_FREQ;
      refclk_prescale_q <= dtis_pkg::RST_REFCLK_PRESCALE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dtis_pkg::CFG_TUNE_FREQ:       tune_freq_q       <= cfg_data_i;
        dtis_pkg::CFG_TUNE_MODE_FLAGS: tune_flags_q      <= cfg_data_i[7:0];
        dtis_pkg::CFG_SAMPLE_RATE:     sample_rate_q     <= cfg_data_i;
        dtis_pkg::CFG_REFCLK_FREQ:     refclk_freq_q     <= cfg_data_i;
        dtis_pkg::CFG_REFCLK_PRESCALE: refclk_prescale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    tgt_q  <= tgt_d;
    byte_q <= byte_d;
    last_q <= last_d;
    mask_q <= mask_d;
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = act_q;
  assign target_tuner_o = tgt_q;
  assign cmd_byte_o     = byte_q;
  assign last_o         = last_q;
  assign up_mask_o      = mask_q;
  assign all_ready_o    = (mask_q == 2'b11);

`ifndef SYNTHESIS
  a_run_pc_in_rom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtis_pkg::ST_RUN) |-> (pc_q <= 5'd28))
    else $error("microcode pc ran past the program");

  a_seq_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q[0] <= dtis_pkg::PH_UP) && (seq_q[1] <= dtis_pkg::PH_UP))
    else $error("tuner phase out of range");

  a_bus_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bus_q[0] != 2'd3) && (bus_q[1] != 2'd3))
    else $error("bus phase out of range");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (act_q != dtis_pkg::ACT_CMD)) |-> last_q)
    else $error("single-result item not marked last");

  a_cmd_run_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtis_pkg::ST_RUN) |-> (run_tgt_q == cur_q))
    else $error("command bytes address the wrong tuner");
`endif

endmodule

FILE: test/tb_dual_tuner_init_sequencer.sv
// Testbench for dual_tuner_init_sequencer: directed bring-up items, then random phases
// with different register settings, idling and a long output hold-off.
// Depends on dtis_pkg and the dual_tuner_init_sequencer RTL.
`timescale 1ns / 1ps

typedef struct packed {
  dtis_pkg::action_e act;
  logic              tgt;
  logic [7:0]        data;
  logic              last;
  logic [1:0]        up;
  logic              rdy;
} tuner_action_t;

typedef logic [7:0] byte_q_t[$];

class bringup_scoreboard;
  logic [15:0] freq;
  logic [7:0]  flags;
  logic [15:0] srate;
  logic [15:0] rcf;
  logic [15:0] rcp;

  logic [3:0]  phase[2];
  logic [1:0]  bphase[2];
  logic        cur;
  logic        cts[2];
  logic        stc[2];
  logic [1:0]  up;

  tuner_action_t expected_actions[$];
  int            errors;

  function new();
    freq   = dtis_pkg::RST_TUNE_FREQ;
    flags  = dtis_pkg::RST_TUNE_MODE_FLAGS;
    srate  = dtis_pkg::RST_SAMPLE_RATE;
    rcf    = dtis_pkg::RST_REFCLK_FREQ;
    rcp    = dtis_pkg::RST_REFCLK_PRESCALE;
    for (int i = 0; i < 2; i++) begin
      phase[i]  = dtis_pkg::PH_DOWN;
      bphase[i] = dtis_pkg::BP_DONE;
      cts[i]    = 1'b0;
      stc[i]    = 1'b0;
    end
    cur    = 1'b1;
    up     = 2'b00;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] d);
    case (idx)
      dtis_pkg::CFG_TUNE_FREQ:       freq  = d;
      dtis_pkg::CFG_TUNE_MODE_FLAGS: flags = d[7:0];
      dtis_pkg::CFG_SAMPLE_RATE:     srate = d;
      dtis_pkg::CFG_REFCLK_FREQ:     rcf   = d;
      dtis_pkg::CFG_REFCLK_PRESCALE: rcp   = d;
      default: ;
    endcase
  endfunction

  function tuner_action_t make_action(dtis_pkg::action_e act, logic t, logic [7:0] data);
    tuner_action_t a;
    a.act  = act;
    a.tgt  = t;
    a.data = data;
    a.last = 1'b0;
    a.up   = 2'b00;
    a.rdy  = 1'b0;
    return a;
  endfunction

  function byte_q_t prop_bytes(logic [7:0] grp, logic [7:0] idx, logic [15:0] v);
    byte_q_t q;
    q = {8'h12, 8'h00, grp, idx, v[15:8], v[7:0]};
    return q;
  endfunction

  function void note_item(logic req, logic busy, logic pwr, logic rt, logic rc, logic rs);
    tuner_action_t burst[$];
    byte_q_t       cmd;
    logic [3:0]    ph;
    logic          t;
    if (req) begin
      cts[rt] = rc;
      stc[rt] = rs;
      return;
    end
    if (busy) return;
    cur = ~cur;
    t   = cur;
    if (bphase[t] == dtis_pkg::BP_CHECK) begin
      bphase[t] = dtis_pkg::BP_READING;
      burst.push_back(make_action(dtis_pkg::ACT_STATUS, t, 8'h00));
    end else if (bphase[t] == dtis_pkg::BP_READING) begin
      bphase[t] = cts[t] ? dtis_pkg::BP_DONE : dtis_pkg::BP_CHECK;
      return;
    end else begin
      bphase[t] = dtis_pkg::BP_DONE;
      ph = (phase[t] > dtis_pkg::PH_UP) ? dtis_pkg::PH_DOWN : phase[t];
      if (ph == dtis_pkg::PH_UP) begin
        if (!pwr) begin
          burst.push_back(make_action(dtis_pkg::ACT_RST_ASSERT, t, 8'h00));
          ph = dtis_pkg::PH_DOWN;
        end
      end else if (ph == dtis_pkg::PH_DOWN) begin
        if (pwr) begin
          burst.push_back(make_action(dtis_pkg::ACT_RST_RELEASE, t, 8'h00));
          ph = 4'd1;
        end
      end else if (ph == dtis_pkg::PH_INT_CLR && !stc[t]) begin
        ph = dtis_pkg::PH_INT_UPDATE;
      end else begin
        // phases 1..7: power up, refclk freq, prescale, tune, int update, int clear, rate
        case (ph)
          4'd1:    cmd = {8'h01, 8'h00, 8'hB5};
          4'd2:    cmd = prop_bytes(8'h02, 8'h01, rcf);
          4'd3:    cmd = prop_bytes(8'h02, 8'h02, rcp);
          4'd4:    cmd = {8'h20, flags, freq[15:8], freq[7:0], 8'h00};
          4'd5:    cmd = {8'h14};
          4'd6:    cmd = {8'h22, 8'h01};
          default: cmd = prop_bytes(8'h01, 8'h04, srate);
        endcase
        foreach (cmd[k]) burst.push_back(make_action(dtis_pkg::ACT_CMD, t, cmd[k]));
        bphase[t] = dtis_pkg::BP_CHECK;
        ph = ph + 4'd1;
      end
      phase[t] = ph;
      up[t]    = (ph == dtis_pkg::PH_UP);
    end
    foreach (burst[k]) begin
      burst[k].last = (k == burst.size() - 1);
      burst[k].up   = up;
      burst[k].rdy  = (up == 2'b11);
      expected_actions.push_back(burst[k]);
    end
  endfunction

  task report(string what);
    $display("check failed: %s", what);
    errors++;
  endtask

  task check_action(tuner_action_t got);
    tuner_action_t want;
    if (expected_actions.size() == 0) begin
      report("output item with nothing pending");
      return;
    end
    want = expected_actions.pop_front();
    if (got.act !== want.act) report($sformatf("action %0d, want %0d", got.act, want.act));
    if (got.tgt !== want.tgt) report($sformatf("tuner %0d, want %0d", got.tgt, want.tgt));
    if (got.data !== want.data) report($sformatf("byte %h, want %h", got.data, want.data));
    if (got.last !== want.last) report($sformatf("last %0d, want %0d", got.last, want.last));
    if (got.up !== want.up) report($sformatf("up_mask %0d, want %0d", got.up, want.up));
    if (got.rdy !== want.rdy) report($sformatf("all_ready %0d, want %0d", got.rdy, want.rdy));
  endtask
endclass

module tb;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_REPLY = 1'b1;
  localparam int   HOLD_CYCLES = 400;
  localparam int   CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        req_type = 1'b0;
  logic        bus_busy = 1'b0;
  logic        power_on = 1'b0;
  logic        reply_tuner = 1'b0;
  logic        reply_cts = 1'b0;
  logic        reply_stcint = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        hold_req = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  action_o;
  logic        target_tuner_o;
  logic [7:0]  cmd_byte_o;
  logic        last_o;
  logic [1:0]  up_mask_o;
  logic        all_ready_o;
  logic        cfg_ready_o;

  int          send_idle = 0;
  int          stall_pct = 0;
  int          hold_cnt = 0;
  int          cycle_cnt = 0;

  bringup_scoreboard sb;
  tuner_action_t     seen;

  dual_tuner_init_sequencer u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type),
    .bus_busy_i     (bus_busy),
    .power_on_i     (power_on),
    .reply_tuner_i  (reply_tuner),
    .reply_cts_i    (reply_cts),
    .reply_stcint_i (reply_stcint),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .action_o       (action_o),
    .target_tuner_o (target_tuner_o),
    .cmd_byte_o     (cmd_byte_o),
    .last_o         (last_o),
    .up_mask_o      (up_mask_o),
    .all_ready_o    (all_ready_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("dual_tuner_init_sequencer: mismatch");
      $finish;
    end
  end

  // output stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      hold_cnt <= HOLD_CYCLES;
    end
    out_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) begin
        sb.note_item(req_type, bus_busy, power_on, reply_tuner, reply_cts, reply_stcint);
      end
      if (out_valid_o && !out_stall) begin
        seen.act  = dtis_pkg::action_e'(action_o);
        seen.tgt  = target_tuner_o;
        seen.data = cmd_byte_o;
        seen.last = last_o;
        seen.up   = up_mask_o;
        seen.rdy  = all_ready_o;
        sb.check_action(seen);
      end
    end
  end

  task send_item(logic req, logic busy, logic pwr, logic rt, logic rc, logic rs);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= req;
    bus_busy     <= busy;
    power_on     <= pwr;
    reply_tuner  <= rt;
    reply_cts    <= rc;
    reply_stcint <= rs;
    do @(posedge clk); while (in_stall_o);
  endtask

  // unused fields carry random values
  task tick(logic busy, logic pwr);
    send_item(REQ_TICK, busy, pwr, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
  endtask

  task reply(logic t, logic c, logic s);
    send_item(REQ_REPLY, 1'($urandom_range(1)), 1'($urandom_range(1)), t, c, s);
  endtask

  task write_regs(logic [15:0] freq, logic [7:0] flags, logic [15:0] srate,
                  logic [15:0] rcf, logic [15:0] rcp);
    logic [2:0]  idx[5];
    logic [15:0] vals[5];
    idx[0] = dtis_pkg::CFG_TUNE_FREQ;       vals[0] = freq;
    idx[1] = dtis_pkg::CFG_TUNE_MODE_FLAGS; vals[1] = {8'h00, flags};
    idx[2] = dtis_pkg::CFG_SAMPLE_RATE;     vals[2] = srate;
    idx[3] = dtis_pkg::CFG_REFCLK_FREQ;     vals[3] = rcf;
    idx[4] = dtis_pkg::CFG_REFCLK_PRESCALE; vals[4] = rcp;
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready_o);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.expected_actions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // mostly powered-on ticks and CTS replies so tuners walk the whole bring-up
  task run_random(int items);
    int  n;
    bit  busy;
    n = 0;
    while (n < items) begin
      if ($urandom_range(99) < 30) begin
        reply(1'($urandom_range(1)), $urandom_range(99) < 85, $urandom_range(99) < 60);
        n++;
      end else begin
        busy = ($urandom_range(99) < 8);
        tick(busy, $urandom_range(99) < 93);
        if (!busy) n++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed bring-up start
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    reply(1'b0, 1'b0, 1'b0);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    reply(1'b1, 1'b1, 1'b1);
    reply(1'b0, 1'b1, 1'b0);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b0);
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b0);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
    drain();

    write_regs(16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    run_random(34);
    drain();

    send_idle = 85;
    write_regs(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(34);
    drain();

    send_idle = 0;
    stall_pct = 85;
    write_regs(16'($urandom_range(65535)), 8'($urandom_range(255)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)));
    run_random(34);
    drain();

    send_idle = 38;
    stall_pct = 38;
    write_regs(16'($urandom_range(65535)), 8'($urandom_range(255)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)));
    run_random(34);
    drain();

    send_idle = 0;
    stall_pct = 0;
    write_regs(dtis_pkg::RST_TUNE_FREQ, dtis_pkg::RST_TUNE_MODE_FLAGS,
               dtis_pkg::RST_SAMPLE_RATE, dtis_pkg::RST_REFCLK_FREQ,
               dtis_pkg::RST_REFCLK_PRESCALE);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_random(34);
    drain();

    if (sb.errors == 0) begin
      $display("dual_tuner_init_sequencer: match");
    end else begin
      $display("dual_tuner_init_sequencer: mismatch");
    end
    $finish;
  end
endmodule
